@@ design/eplc_pkg.sv @@
// Shared types and constants for the entry point LRU cache.
// Used by the entry_point_lru_cache top level and its testbench.
// No dependencies.
package eplc_pkg;

  // Default number of slots in the slot store.
  localparam int SLOT_COUNT_DEF = 128;
  // Hard upper bound on the number of slots that are ever filled.
  localparam int CAP_CEILING = 128;
  // Capacity register value after reset.
  localparam logic [7:0] CAP_RESET = 8'd128;

  localparam int KEY_W   = 32;
  localparam int BLOCK_W = 32;
  localparam int LEVEL_W = 8;
  localparam int STAMP_W = 32;
  localparam int COUNT_W = 8;

  typedef enum logic [1:0] {
    REQ_LOOKUP     = 2'd0,
    REQ_STORE      = 2'd1,
    REQ_INVALIDATE = 2'd2,
    REQ_CLEAR      = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    OUT_MISS        = 3'd0,
    OUT_HIT         = 3'd1,
    OUT_UPDATED     = 3'd2,
    OUT_INSERTED    = 3'd3,
    OUT_REPLACED    = 3'd4,
    OUT_INVALIDATED = 3'd5,
    OUT_CLEARED     = 3'd6
  } outcome_t;

  // One slot as it is kept in the slot RAM.
  typedef struct packed {
    logic               valid;
    logic [STAMP_W-1:0] stamp;
    logic [LEVEL_W-1:0] top_level;
    logic [LEVEL_W-1:0] entry_level;
    logic [BLOCK_W-1:0] block;
    logic [KEY_W-1:0]   key;
  } slot_t;

endpackage

@@ design/eplc_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the slot store of the entry point LRU cache; no other dependencies.
module eplc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/entry_point_lru_cache.sv @@
// Entry point LRU cache: fully associative key cache with oldest-stamp replacement.
// Depends on eplc_pkg and on the generic RAM eplc_ram, which holds all slots.
// A request is taken only while no other is in flight. Lookup, store and invalidate
// scan the used slots of the slot RAM through its single read port, one slot per cycle,
// and then wait for the output register; a clear skips the scan.
// Reset (synchronous, active high) empties the cache, sets the access counter to one
// and the capacity limit to 128; the slot RAM itself needs no clearing pass.
module entry_point_lru_cache
  import eplc_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Capacity limit register write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: key [31:0], entry_block [63:32], entry_level [71:64], top_level [79:72].
  input  logic [79:0] s_axis_tdata,
  // tuser: req_type [1:0].
  input  logic [1:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: found_block [31:0], found_entry_level [39:32], found_top_level [47:40],
  // used_count [55:48], valid_slots [63:56].
  output logic [63:0] m_axis_tdata,
  // tuser: outcome [2:0].
  output logic [2:0]  m_axis_tuser
);

  // Slots that can ever be filled, and the widths that follow from it.
  localparam int CAP_TOP = (CAP_CEILING < SLOT_COUNT) ? CAP_CEILING : SLOT_COUNT;
  localparam int UCNT_W  = $clog2(CAP_TOP + 1);
  localparam int IDX_W   = $clog2(SLOT_COUNT);
  localparam logic [7:0] CAP_TOP8 = 8'(CAP_TOP);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_SCAN    = 3'b010,
    ST_RESOLVE = 3'b100
  } state_t;

  state_t state;

  // Architectural state outside the slot RAM. Slots at or above slots_used are
  // never read, so a clear only has to reset the counts: every slot below the
  // used count has been written since the last clear and carries its own valid bit.
  logic [7:0]         cap_limit;
  logic [UCNT_W-1:0]  slots_used;
  logic [UCNT_W-1:0]  valid_slots;
  logic [STAMP_W-1:0] access_counter;

  // Latched request.
  req_type_t          req_type;
  logic [KEY_W-1:0]   req_key;
  logic [BLOCK_W-1:0] req_block;
  logic [LEVEL_W-1:0] req_entry_level;
  logic [LEVEL_W-1:0] req_top_level;

  // Scan state. The RAM read is registered, so a slot returns in the cycle after its
  // address is issued, and rd_pend and rd_idx are registered to follow the address.
  logic [UCNT_W-1:0]  scan_cnt;
  logic               rd_pend;
  logic [IDX_W-1:0]   rd_idx;
  logic               match_found;
  logic [IDX_W-1:0]   match_idx;
  slot_t              match_slot;
  logic               victim_found;
  logic [IDX_W-1:0]   victim_idx;
  logic               victim_valid;
  logic [STAMP_W-1:0] oldest;

  // Slot RAM ports.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  slot_t            ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  slot_t            ram_rdata;

  eplc_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The capacity register is always writable; the user must write it only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  // A new request is taken whenever no other is in flight, even if the previous
  // result still waits at the output register.
  assign s_axis_tready = (state == ST_IDLE);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Effective capacity: zero acts as one, and the value is clamped to CAP_TOP.
  logic [7:0]        cap_clamped;
  logic [UCNT_W-1:0] cap_eff;
  always_comb begin
    if (cap_limit == 8'd0) begin
      cap_clamped = 8'd1;
    end else if (cap_limit > CAP_TOP8) begin
      cap_clamped = CAP_TOP8;
    end else begin
      cap_clamped = cap_limit;
    end
    cap_eff = UCNT_W'(cap_clamped);
  end

  logic scan_issue;
  assign scan_issue = (state == ST_SCAN) && (scan_cnt < slots_used);
  assign ram_raddr  = IDX_W'(scan_cnt);

  // Resolution happens once the output register is free to take the result.
  logic resolve_fire;
  assign resolve_fire = (state == ST_RESOLVE) && (!m_axis_tvalid || m_axis_tready);

  // Outcome of the request and the single write back into the slot RAM.
  outcome_t           res_outcome;
  logic [BLOCK_W-1:0] res_block;
  logic [LEVEL_W-1:0] res_entry_level;
  logic [LEVEL_W-1:0] res_top_level;
  logic [UCNT_W-1:0]  used_next;
  logic [UCNT_W-1:0]  valid_next;
  logic               stamp_take;
  logic               wr_en;
  slot_t              store_slot;

  always_comb begin
    store_slot.valid       = 1'b1;
    store_slot.stamp       = access_counter;
    store_slot.top_level   = req_top_level;
    store_slot.entry_level = req_entry_level;
    store_slot.block       = req_block;
    store_slot.key         = req_key;

    res_outcome     = OUT_MISS;
    res_block       = '0;
    res_entry_level = '0;
    res_top_level   = '0;
    used_next       = slots_used;
    valid_next      = valid_slots;
    stamp_take      = 1'b0;
    wr_en           = 1'b0;
    ram_waddr       = match_idx;
    ram_wdata       = store_slot;

    case (req_type)
      REQ_LOOKUP: begin
        if (match_found) begin
          res_outcome     = OUT_HIT;
          res_block       = match_slot.block;
          res_entry_level = match_slot.entry_level;
          res_top_level   = match_slot.top_level;
          stamp_take      = 1'b1;
          wr_en           = 1'b1;
          ram_wdata       = match_slot;
          ram_wdata.stamp = access_counter;
        end
      end
      REQ_STORE: begin
        if (match_found) begin
          res_outcome = OUT_UPDATED;
          stamp_take  = 1'b1;
          wr_en       = 1'b1;
        end else if (slots_used < cap_eff) begin
          // Fill the next unused slot.
          res_outcome = OUT_INSERTED;
          stamp_take  = 1'b1;
          wr_en       = 1'b1;
          ram_waddr   = IDX_W'(slots_used);
          used_next   = slots_used + UCNT_W'(1);
          valid_next  = valid_slots + UCNT_W'(1);
        end else if (victim_found) begin
          // Replace the oldest slot; an invalidated victim becomes valid again.
          res_outcome = OUT_REPLACED;
          stamp_take  = 1'b1;
          wr_en       = 1'b1;
          ram_waddr   = victim_idx;
          if (!victim_valid) begin
            valid_next = valid_slots + UCNT_W'(1);
          end
        end
      end
      REQ_INVALIDATE: begin
        res_outcome = OUT_INVALIDATED;
        if (match_found) begin
          wr_en           = 1'b1;
          ram_wdata       = match_slot;
          ram_wdata.valid = 1'b0;
          valid_next      = valid_slots - UCNT_W'(1);
        end
      end
      REQ_CLEAR: begin
        res_outcome = OUT_CLEARED;
        used_next   = '0;
        valid_next  = '0;
      end
      default: begin
        res_outcome = OUT_MISS;
      end
    endcase

    ram_we = resolve_fire && wr_en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cap_limit      <= CAP_RESET;
      slots_used     <= '0;
      valid_slots    <= '0;
      access_counter <= STAMP_W'(1);
      rd_pend        <= 1'b0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_limit <= cfg_data;
      end

      // A new result takes the output register; otherwise a transfer empties it.
      if (resolve_fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          rd_pend <= 1'b0;
          if (in_xfer) begin
            if (req_type_t'(s_axis_tuser) == REQ_CLEAR) begin
              state <= ST_RESOLVE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          rd_pend <= scan_issue;
          if (!scan_issue && !rd_pend) begin
            state <= ST_RESOLVE;
          end
        end
        ST_RESOLVE: begin
          if (resolve_fire) begin
            slots_used  <= used_next;
            valid_slots <= valid_next;
            if (stamp_take) begin
              access_counter <= access_counter + STAMP_W'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Request latch, scan bookkeeping and result payload carry no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_type        <= req_type_t'(s_axis_tuser);
      req_key         <= s_axis_tdata[31:0];
      req_block       <= s_axis_tdata[63:32];
      req_entry_level <= s_axis_tdata[71:64];
      req_top_level   <= s_axis_tdata[79:72];
      scan_cnt        <= '0;
      match_found     <= 1'b0;
      victim_found    <= 1'b0;
      // Only stamps strictly below the current counter qualify as oldest.
      oldest          <= access_counter;
    end

    if (scan_issue) begin
      scan_cnt <= scan_cnt + UCNT_W'(1);
    end
    rd_idx <= ram_raddr;

    if (state == ST_SCAN && rd_pend) begin
      // The first valid slot with a matching key wins.
      if (ram_rdata.valid && ram_rdata.key == req_key && !match_found) begin
        match_found <= 1'b1;
        match_idx   <= rd_idx;
        match_slot  <= ram_rdata;
      end
      // Oldest stamp over all used slots, valid or not; ties keep the first.
      if (ram_rdata.stamp < oldest) begin
        oldest       <= ram_rdata.stamp;
        victim_found <= 1'b1;
        victim_idx   <= rd_idx;
        victim_valid <= ram_rdata.valid;
      end
    end

    if (resolve_fire) begin
      m_axis_tuser  <= res_outcome;
      m_axis_tdata  <= {8'(valid_next), 8'(used_next), res_top_level,
                        res_entry_level, res_block};
    end
  end

endmodule

@@ sim/tb_entry_point_lru_cache.sv @@
// Self-checking testbench for the entry point LRU cache (entry_point_lru_cache).
// Holds its own cache predictor, a stream driver and a result monitor; depends on eplc_pkg
// and the design files only.
module tb_entry_point_lru_cache
  import eplc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Slots that can ever be filled, whatever the capacity register says.
  localparam int CAP_TOP = (CAP_CEILING < SLOT_COUNT_DEF) ? CAP_CEILING : SLOT_COUNT_DEF;
  // A full cache scans every used slot per request; the limit leaves a wide margin over
  // every request waiting out long stalls on both sides.
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int RX_HOLD_CYCLES = 600;
  localparam int MAX_PRINTS = 60;
  localparam int KEY_POOL_SIZE = 200;

  // One request as the driver presents it.
  typedef struct {
    req_type_t            kind;
    logic [KEY_W-1:0]     key;
    logic [BLOCK_W-1:0]   block;
    logic [LEVEL_W-1:0]   entry_level;
    logic [LEVEL_W-1:0]   top_level;
  } cache_req_t;

  // One result as the monitor sees it.
  typedef struct {
    outcome_t             outcome;
    logic [BLOCK_W-1:0]   block;
    logic [LEVEL_W-1:0]   entry_level;
    logic [LEVEL_W-1:0]   top_level;
    logic [COUNT_W-1:0]   used;
    logic [COUNT_W-1:0]   valid;
  } cache_resp_t;

  // All inputs of the block hold known values from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  entry_point_lru_cache dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Cache predictor. It mirrors the slot store, the used count, the access
  // counter and the capacity register, and is advanced once per accepted request.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0]   shadow_key         [SLOT_COUNT_DEF];
  logic [BLOCK_W-1:0] shadow_block       [SLOT_COUNT_DEF];
  logic [LEVEL_W-1:0] shadow_entry_level [SLOT_COUNT_DEF];
  logic [LEVEL_W-1:0] shadow_top_level   [SLOT_COUNT_DEF];
  logic [STAMP_W-1:0] shadow_stamp       [SLOT_COUNT_DEF];
  logic               shadow_valid       [SLOT_COUNT_DEF];
  int unsigned        slots_filled = 0;
  logic [STAMP_W-1:0] stamp_clock = 32'd1;
  logic [7:0]         capacity_reg = CAP_RESET;
  int                 outcome_tally [7];

  initial begin
    for (int i = 0; i < SLOT_COUNT_DEF; i++) shadow_valid[i] = 1'b0;
    for (int i = 0; i < 7; i++) outcome_tally[i] = 0;
  end

  // Writes a request into one slot and stamps it with the access counter.
  function automatic void fill_slot(input int idx, input cache_req_t r);
    shadow_key[idx]         = r.key;
    shadow_block[idx]       = r.block;
    shadow_entry_level[idx] = r.entry_level;
    shadow_top_level[idx]   = r.top_level;
    shadow_stamp[idx]       = stamp_clock;
    shadow_valid[idx]       = 1'b1;
    stamp_clock             = stamp_clock + 32'd1;
  endfunction

  function automatic cache_resp_t predict_cache(input cache_req_t r);
    cache_resp_t        o;
    int                 hit;
    int                 victim;
    int unsigned        eff_cap;
    int unsigned        nvalid;
    logic [STAMP_W-1:0] oldest;
    o.outcome     = OUT_MISS;
    o.block       = '0;
    o.entry_level = '0;
    o.top_level   = '0;
    hit = -1;
    // The first valid slot with a matching key wins; only used slots are searched.
    for (int i = 0; i < int'(slots_filled); i++) begin
      if (hit < 0 && shadow_valid[i] && shadow_key[i] == r.key) hit = i;
    end
    case (r.kind)
      REQ_LOOKUP: begin
        if (hit >= 0) begin
          o.outcome         = OUT_HIT;
          o.block           = shadow_block[hit];
          o.entry_level     = shadow_entry_level[hit];
          o.top_level       = shadow_top_level[hit];
          shadow_stamp[hit] = stamp_clock;
          stamp_clock       = stamp_clock + 32'd1;
        end
      end
      REQ_STORE: begin
        // A register value of zero acts as one, anything above the ceiling as the ceiling.
        eff_cap = (capacity_reg == 0) ? 1 : (capacity_reg > CAP_TOP) ? CAP_TOP : capacity_reg;
        if (hit >= 0) begin
          fill_slot(hit, r);
          o.outcome = OUT_UPDATED;
        end else if (slots_filled < eff_cap) begin
          fill_slot(slots_filled, r);
          slots_filled++;
          o.outcome = OUT_INSERTED;
        end else begin
          // Oldest stamp among the used slots, valid or not; ties keep the lowest index.
          oldest = stamp_clock;
          victim = -1;
          for (int i = 0; i < int'(slots_filled); i++) begin
            if (shadow_stamp[i] < oldest) begin
              oldest = shadow_stamp[i];
              victim = i;
            end
          end
          if (victim >= 0) begin
            fill_slot(victim, r);
            o.outcome = OUT_REPLACED;
          end
        end
      end
      REQ_INVALIDATE: begin
        // The slot stays counted as used; a miss reports the same outcome.
        if (hit >= 0) shadow_valid[hit] = 1'b0;
        o.outcome = OUT_INVALIDATED;
      end
      default: begin
        for (int i = 0; i < SLOT_COUNT_DEF; i++) shadow_valid[i] = 1'b0;
        slots_filled = 0;
        o.outcome    = OUT_CLEARED;
      end
    endcase
    nvalid = 0;
    for (int i = 0; i < int'(slots_filled); i++) if (shadow_valid[i]) nvalid++;
    o.used  = slots_filled[COUNT_W-1:0];
    o.valid = nvalid[COUNT_W-1:0];
    outcome_tally[int'(o.outcome)]++;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Queues, knobs and counters shared by the processes below.
  // ---------------------------------------------------------------------------
  cache_req_t  pending_reqs[$];     // requests waiting for the driver
  cache_resp_t expected_resps[$];   // predicted results, oldest first
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          mismatch_count = 0;
  int          requests_sent = 0;
  int          results_checked = 0;
  int          capacity_writes = 0;
  int          hold_requests = 0;
  int          holds_done = 0;
  int          rx_hold_left = 0;
  int unsigned cycle_count = 0;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
               $realtime, results_checked, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued requests on the request stream. A new request is only
  // loaded once the previous one has been transferred, so tvalid never drops
  // while a request is waiting. The prediction is made at the transfer edge.
  // ---------------------------------------------------------------------------
  cache_req_t req_on_bus;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_resps.push_back(predict_cache(req_on_bus));
        requests_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          req_on_bus    = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {req_on_bus.top_level, req_on_bus.entry_level,
                            req_on_bus.block, req_on_bus.key};
          s_axis_tuser  <= req_on_bus.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver hold-off: on request, tready is kept low for a long stretch so that
  // the block fills up and stalls its request stream.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rx_hold_left <= 0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (hold_requests != holds_done) begin
      rx_hold_left <= RX_HOLD_CYCLES;
      holds_done   <= holds_done + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result transfer is checked field by field against the oldest
  // prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cache_resp_t want;
    cache_resp_t got;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.outcome     = outcome_t'(m_axis_tuser);
        got.block       = m_axis_tdata[31:0];
        got.entry_level = m_axis_tdata[39:32];
        got.top_level   = m_axis_tdata[47:40];
        got.used        = m_axis_tdata[55:48];
        got.valid       = m_axis_tdata[63:56];
        if (expected_resps.size() == 0) begin
          report_mismatch("arrived with nothing expected", m_axis_tdata, 0);
        end else begin
          want = expected_resps.pop_front();
          if (got.outcome != want.outcome)
            report_mismatch("outcome", got.outcome, want.outcome);
          if (got.block != want.block)
            report_mismatch("found_block", got.block, want.block);
          if (got.entry_level != want.entry_level)
            report_mismatch("found_entry_level", got.entry_level, want.entry_level);
          if (got.top_level != want.top_level)
            report_mismatch("found_top_level", got.top_level, want.top_level);
          if (got.used != want.used)
            report_mismatch("used_count", got.used, want.used);
          if (got.valid != want.valid)
            report_mismatch("valid_slots", got.valid, want.valid);
        end
        results_checked++;
      end
      m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_resps.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] key_pool[KEY_POOL_SIZE];

  task automatic push_req(input req_type_t kind, input logic [KEY_W-1:0] key,
                          input logic [BLOCK_W-1:0] block,
                          input logic [LEVEL_W-1:0] entry_level,
                          input logic [LEVEL_W-1:0] top_level);
    cache_req_t r;
    r.kind        = kind;
    r.key         = key;
    r.block       = block;
    r.entry_level = entry_level;
    r.top_level   = top_level;
    pending_reqs.push_back(r);
  endtask

  // Waits until every queued request has been transferred and every result has
  // come back. Each request yields a result, so nothing is left working after that.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_resps.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Capacity register write, made only while the block is idle.
  task automatic set_capacity(input logic [7:0] cap);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    capacity_reg = cap;
    capacity_writes++;
    cfg_valid <= 1'b0;
  endtask

  function automatic cache_req_t random_request(input int pool_n, input int store_pct,
                                                input int clear_pct);
    cache_req_t r;
    int         roll;
    roll = $urandom_range(0, 99);
    if (roll < clear_pct)                         r.kind = REQ_CLEAR;
    else if (roll < clear_pct + store_pct)        r.kind = REQ_STORE;
    else if (roll < clear_pct + store_pct + 15)   r.kind = REQ_INVALIDATE;
    else                                          r.kind = REQ_LOOKUP;
    // Mostly keys from a small pool so that hits and updates are common; now and
    // then a fresh key that misses.
    if ($urandom_range(0, 19) == 0) r.key = $urandom;
    else                            r.key = key_pool[$urandom_range(0, pool_n - 1)];
    case ($urandom_range(0, 9))
      0:       r.block = '0;
      1:       r.block = '1;
      default: r.block = $urandom;
    endcase
    r.entry_level = LEVEL_W'($urandom_range(0, 255));
    r.top_level   = LEVEL_W'($urandom_range(0, 255));
    return r;
  endfunction

  // One random phase: capacity setting, idle mix, then a batch of requests.
  task automatic run_phase(input logic [7:0] cap, input int n_items, input int store_pct,
                           input int clear_pct, input int tx_idle, input int rx_idle);
    int eff_cap;
    int pool_n;
    set_capacity(cap);
    tx_idle_pct = tx_idle;
    rx_idle_pct = rx_idle;
    eff_cap = (cap == 0) ? 1 : (cap > CAP_TOP) ? CAP_TOP : cap;
    pool_n  = eff_cap + eff_cap / 2 + 2;
    if (pool_n > KEY_POOL_SIZE) pool_n = KEY_POOL_SIZE;
    repeat (n_items) pending_reqs.push_back(random_request(pool_n, store_pct, clear_pct));
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with the sender idling lightly and the receiver heavily.
    tx_idle_pct = 12;
    rx_idle_pct = 78;

    // Two slots: miss and invalidate on an empty cache, inserts with extreme
    // fields, hits, an update, replacement of the oldest slot, and a store that
    // follows an invalidation and replaces the oldest slot, not the invalidated one.
    set_capacity(8'd2);
    push_req(REQ_LOOKUP,     32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00);
    push_req(REQ_INVALIDATE, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    push_req(REQ_STORE,      32'h0000_0000, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    push_req(REQ_STORE,      32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 8'h00);
    push_req(REQ_LOOKUP,     32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 8'h00);
    push_req(REQ_LOOKUP,     32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00);
    push_req(REQ_STORE,      32'h0000_0000, 32'h1234_5678, 8'h01, 8'h02);
    push_req(REQ_STORE,      32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'hA5, 8'h5A);
    push_req(REQ_LOOKUP,     32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 8'h00);
    push_req(REQ_INVALIDATE, 32'hA5A5_A5A5, 32'h0000_0000, 8'h00, 8'h00);
    push_req(REQ_LOOKUP,     32'hA5A5_A5A5, 32'h0000_0000, 8'h00, 8'h00);
    push_req(REQ_STORE,      32'h5A5A_5A5A, 32'hA5A5_A5A5, 8'h5A, 8'hA5);

    // A register value of zero acts as one, below the two slots in use, so stores
    // replace among the used slots until a clear.
    set_capacity(8'd0);
    push_req(REQ_STORE,      32'h1111_1111, 32'h0F0F_0F0F, 8'h80, 8'h7F);
    push_req(REQ_LOOKUP,     32'h1111_1111, 32'h0000_0000, 8'h00, 8'h00);
    push_req(REQ_CLEAR,      32'h1111_1111, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    push_req(REQ_LOOKUP,     32'h1111_1111, 32'h0000_0000, 8'h00, 8'h00);
    push_req(REQ_STORE,      32'h2222_2222, 32'hF0F0_F0F0, 8'h7F, 8'h80);
    push_req(REQ_STORE,      32'h3333_3333, 32'h0000_0001, 8'h01, 8'hFE);

    // A value above the ceiling acts as the ceiling; an invalidated key is stored
    // again into a fresh slot.
    set_capacity(8'd255);
    push_req(REQ_STORE,      32'h4444_4444, 32'h8000_0000, 8'hFE, 8'h01);
    push_req(REQ_INVALIDATE, 32'h3333_3333, 32'h0000_0000, 8'h00, 8'h00);
    push_req(REQ_STORE,      32'h3333_3333, 32'h7FFF_FFFF, 8'h33, 8'h44);
    push_req(REQ_LOOKUP,     32'h3333_3333, 32'h0000_0000, 8'h00, 8'h00);
    push_req(REQ_CLEAR,      32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00);

    // Random part. The cache is not cleared between phases, so lowering the
    // capacity leaves more slots in use than the new limit allows. Each phase
    // starts only after every result of the one before has come back.
    run_phase(8'd255, 300, 55, 0, 12, 78);
    run_phase(8'd128, 150, 45, 0, 12, 78);
    run_phase(8'd5,    80, 40, 2, 12, 78);
    run_phase(8'd1,    60, 40, 2, 12, 78);
    run_phase(8'd16,  120, 40, 2, 78, 12);
    run_phase(8'd3,    80, 40, 2, 78, 12);
    run_phase(8'd128, 200, 55, 0, 78, 12);
    run_phase(8'd64,  120, 45, 1, 0, 0);
    // Long receiver stall while the sender keeps offering this batch.
    hold_requests = hold_requests + 1;
    run_phase(8'd200, 100, 45, 1, 0, 0);
    run_phase(8'd7,    90, 40, 2, 0, 0);

    wait_drained();
    repeat (140) @(posedge clk);

    $display("Covered %0d requests and %0d results over %0d capacity settings.",
             requests_sent, results_checked, capacity_writes);
    $display("Outcomes: %0d miss, %0d hit, %0d upd, %0d ins, %0d repl, %0d inval, %0d clr",
             outcome_tally[0], outcome_tally[1], outcome_tally[2], outcome_tally[3],
             outcome_tally[4], outcome_tally[5], outcome_tally[6]);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
